// ===== design/pfe_pkg.sv =====
package pfe_pkg;

  localparam int unsigned Side        = 5;
  localparam int unsigned Cells       = 25;
  localparam int unsigned Letters     = 26;
  localparam int unsigned LetterW     = 5;
  localparam int unsigned CellW       = 5;
  localparam int unsigned RowW        = 3;
  localparam int unsigned OpW         = 3;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [LetterW-1:0] ResetOmitted = 5'd16;
  localparam logic [LetterW-1:0] ResetFiller  = 5'd23;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_KEY    = 3'd1,
    OP_FINISH = 3'd2,
    OP_MSG    = 3'd3,
    OP_END    = 3'd4
  } pfe_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OMITTED = 2'd0,
    CFG_FILLER  = 2'd1
  } pfe_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_CELL,
    ST_SQR
  } pfe_state_e;

  typedef struct packed {
    pfe_op_e            kind;
    logic [LetterW-1:0] letter;
    logic               letter_ok;
  } pfe_cmd_t;

  typedef struct packed {
    logic     valid;
    pfe_cmd_t cmd;
  } pfe_q_t;

  function automatic logic [RowW-1:0] pos_row(logic [CellW-1:0] p);
    logic [RowW-1:0] r;
    if (p >= CellW'(4 * Side)) r = 3'd4;
    else if (p >= CellW'(3 * Side)) r = 3'd3;
    else if (p >= CellW'(2 * Side)) r = 3'd2;
    else if (p >= CellW'(Side)) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [RowW-1:0] pos_col(logic [CellW-1:0] p);
    logic [CellW-1:0] c;
    c = p - CellW'(pos_row(p)) * CellW'(Side);
    return c[RowW-1:0];
  endfunction

  function automatic logic [RowW-1:0] wrap_inc(logic [RowW-1:0] x);
    logic [RowW-1:0] y;
    if (x == RowW'(Side - 1)) y = '0;
    else y = x + 1'b1;
    return y;
  endfunction

  function automatic logic [CellW-1:0] cell_at(logic [RowW-1:0] r, logic [RowW-1:0] c);
    logic [CellW-1:0] p;
    p = CellW'(r) * CellW'(Side) + CellW'(c);
    return p;
  endfunction

endpackage

// ===== design/pfe_intf.sv =====
interface pfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::OpW-1:0]     opcode;
  logic [pfe_pkg::LetterW-1:0] letter;
  modport source (output valid, opcode, letter, input ready);
  modport sink   (input valid, opcode, letter, output ready);
endinterface

interface pfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::LetterW-1:0] cipher_first;
  logic [pfe_pkg::LetterW-1:0] cipher_second;
  modport source (output valid, cipher_first, cipher_second, input ready);
  modport sink   (input valid, cipher_first, cipher_second, output ready);
endinterface

interface pfe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::CfgIdxW-1:0] index;
  logic [pfe_pkg::LetterW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/playfair_digraph_encryptor_unit.sv =====
// Playfair digraph encryptor.
// in_i carries opcode/letter items (clear, key letter, finish key, message
// letter, end of message); out_o carries one encrypted digraph per result;
// cfg_i writes the omitted letter (index 0) and the filler letter (index 1),
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. Items enter a command queue of QDepth
// entries; the engine pops one per cycle when idle, that is when no digraph
// is in flight and no key fill is running. Clear, key letter and end of
// message without a result are done as they are popped; finish key walks
// all 26 letters. A message item that closes a digraph then steps through
// position read, cell read and output load, as the position and square
// tables have registered reads. Reset empties the queue and the square,
// drops any open digraph and loads the omitted letter q and filler x. A
// stalled receiver holds the result in the output register; the engine
// waits before loading the next result while the queue keeps taking input
// until full.
module playfair_digraph_encryptor_unit #(
  parameter int unsigned QDepth = pfe_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfe_in_if.sink     in_i,
  pfe_out_if.source  out_o,
  pfe_cfg_if.sink    cfg_i
);

  logic [pfe_pkg::LetterW-1:0] omitted_q, omitted_d;
  logic [pfe_pkg::LetterW-1:0] filler_q, filler_d;
  pfe_pkg::pfe_q_t             q;
  logic                        pop;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    omitted_d = omitted_q;
    filler_d  = filler_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        pfe_pkg::CFG_OMITTED: omitted_d = cfg_i.data;
        pfe_pkg::CFG_FILLER:  filler_d  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omitted_q <= pfe_pkg::ResetOmitted;
      filler_q  <= pfe_pkg::ResetFiller;
    end else begin
      omitted_q <= omitted_d;
      filler_q  <= filler_d;
    end
  end

  pfe_front #(.QDepth(QDepth)) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .omitted_i (omitted_q),
    .pop_i     (pop),
    .q_o       (q)
  );

  pfe_back u_back (
    .clk_i,
    .rst_ni,
    .q_i       (q),
    .pop_o     (pop),
    .omitted_i (omitted_q),
    .filler_i  (filler_q),
    .out_o
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q.valid)
    else $error("pop from empty queue");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q.valid)
    else $error("input stalled with empty queue");

  a_finish_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q.cmd.kind == pfe_pkg::OP_FINISH) |=> !pop)
    else $error("pop during key fill");

endmodule

// ===== design/pfe_front.sv =====
module pfe_front #(
  parameter int unsigned QDepth = pfe_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pfe_in_if.sink                      in_i,
  input  logic [pfe_pkg::LetterW-1:0] omitted_i,
  input  logic                        pop_i,
  output pfe_pkg::pfe_q_t             q_o
);

  // QDepth >= 2
  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  pfe_pkg::pfe_cmd_t mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  pfe_pkg::pfe_cmd_t cmd;
  logic              known;
  logic              push;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(QDepth - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  always_comb begin
    cmd.kind      = pfe_pkg::pfe_op_e'(in_i.opcode);
    cmd.letter    = in_i.letter;
    cmd.letter_ok = (in_i.letter < pfe_pkg::LetterW'(pfe_pkg::Letters)) &&
                    (in_i.letter != omitted_i);
    case (in_i.opcode)
      pfe_pkg::OP_CLEAR, pfe_pkg::OP_KEY, pfe_pkg::OP_FINISH,
      pfe_pkg::OP_MSG, pfe_pkg::OP_END: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  // unused opcodes are taken and dropped
  assign in_i.ready = (cnt_q != CntW'(QDepth));
  assign push       = in_i.valid && in_i.ready && known;

  always_comb begin
    wr_ptr_d = push  ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.cmd   = mem_q[rd_ptr_q];

endmodule

// ===== design/pfe_back.sv =====
module pfe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfe_pkg::pfe_q_t             q_i,
  output logic                        pop_o,
  input  logic [pfe_pkg::LetterW-1:0] omitted_i,
  input  logic [pfe_pkg::LetterW-1:0] filler_i,
  pfe_out_if.source                   out_o
);

  localparam int unsigned LW = pfe_pkg::LetterW;
  localparam int unsigned CW = pfe_pkg::CellW;
  localparam int unsigned RW = pfe_pkg::RowW;

  pfe_pkg::pfe_state_e state_q, state_d;

  logic [pfe_pkg::Letters-1:0] used_q, used_d;
  logic [CW-1:0]               fill_q, fill_d;
  logic [LW-1:0]               pend_q, pend_d;
  logic                        pend_vld_q, pend_vld_d;
  logic [LW-1:0]               idx_q, idx_d;
  logic [LW-1:0]               a_q, a_d, b_q, b_d;
  logic                        b_placed_q, b_placed_d;
  logic                        out_vld_q, out_vld_d;
  logic [LW-1:0]               cf_q, cf_d, cs_q, cs_d;

  logic [LW-1:0] sq_mem  [pfe_pkg::Cells];
  logic [CW-1:0] pos_mem [pfe_pkg::Letters];
  logic [CW-1:0] pos_a_q, pos_b_q;
  logic [LW-1:0] sq_a_q, sq_b_q;

  logic          place_cand, place_en;
  logic [LW-1:0] place_l;
  logic          full, filler_placed, load;
  logic [CW-1:0] pa, pb, qa, qb;
  logic [RW-1:0] ra, ca, rb, cb;

  assign full          = (fill_q == CW'(pfe_pkg::Cells));
  assign filler_placed = (filler_i < LW'(pfe_pkg::Letters)) && used_q[filler_i];

  always_comb begin
    if (state_q == pfe_pkg::ST_FILL) begin
      place_l    = idx_q;
      place_cand = (idx_q != omitted_i);
    end else begin
      place_l    = q_i.cmd.letter;
      place_cand = (state_q == pfe_pkg::ST_IDLE) && q_i.valid &&
                   (q_i.cmd.kind == pfe_pkg::OP_KEY) && q_i.cmd.letter_ok;
    end
    place_en = place_cand && !full && !used_q[place_l];
  end

  always_comb begin
    pa = pos_a_q;
    pb = b_placed_q ? pos_b_q : '0;
    ra = pfe_pkg::pos_row(pa);
    ca = pfe_pkg::pos_col(pa);
    rb = pfe_pkg::pos_row(pb);
    cb = pfe_pkg::pos_col(pb);
    if (ra == rb) begin
      qa = pfe_pkg::cell_at(ra, pfe_pkg::wrap_inc(ca));
      qb = pfe_pkg::cell_at(rb, pfe_pkg::wrap_inc(cb));
    end else if (ca == cb) begin
      qa = pfe_pkg::cell_at(pfe_pkg::wrap_inc(ra), ca);
      qb = pfe_pkg::cell_at(pfe_pkg::wrap_inc(rb), cb);
    end else begin
      qa = pfe_pkg::cell_at(ra, cb);
      qb = pfe_pkg::cell_at(rb, ca);
    end
  end

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    fill_d     = fill_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    idx_d      = idx_q;
    a_d        = a_q;
    b_d        = b_q;
    b_placed_d = b_placed_q;
    pop_o      = 1'b0;
    load       = 1'b0;

    if (place_en) begin
      used_d[place_l] = 1'b1;
      fill_d          = fill_q + 1'b1;
    end

    case (state_q)
      pfe_pkg::ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          case (q_i.cmd.kind)
            pfe_pkg::OP_CLEAR: begin
              used_d     = '0;
              fill_d     = '0;
              pend_d     = '0;
              pend_vld_d = 1'b0;
            end
            pfe_pkg::OP_FINISH: begin
              idx_d   = '0;
              state_d = pfe_pkg::ST_FILL;
            end
            pfe_pkg::OP_MSG: begin
              if (full && q_i.cmd.letter_ok && used_q[q_i.cmd.letter]) begin
                if (!pend_vld_q) begin
                  pend_d     = q_i.cmd.letter;
                  pend_vld_d = 1'b1;
                end else begin
                  a_d     = pend_q;
                  state_d = pfe_pkg::ST_POS;
                  if (q_i.cmd.letter == pend_q) begin
                    b_d        = filler_i;
                    b_placed_d = filler_placed;
                  end else begin
                    b_d        = q_i.cmd.letter;
                    b_placed_d = 1'b1;
                    pend_vld_d = 1'b0;
                  end
                end
              end
            end
            pfe_pkg::OP_END: begin
              if (full && pend_vld_q) begin
                a_d        = pend_q;
                b_d        = filler_i;
                b_placed_d = filler_placed;
                pend_vld_d = 1'b0;
                state_d    = pfe_pkg::ST_POS;
              end
            end
            default: ;
          endcase
        end
      end
      pfe_pkg::ST_FILL: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LW'(pfe_pkg::Letters - 1)) begin
          state_d = pfe_pkg::ST_IDLE;
        end
      end
      pfe_pkg::ST_POS:  state_d = pfe_pkg::ST_CELL;
      pfe_pkg::ST_CELL: state_d = pfe_pkg::ST_SQR;
      pfe_pkg::ST_SQR: begin
        if (!out_vld_q || out_o.ready) begin
          load    = 1'b1;
          state_d = pfe_pkg::ST_IDLE;
        end
      end
      default: state_d = pfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    cf_d      = cf_q;
    cs_d      = cs_q;
    if (load) begin
      out_vld_d = 1'b1;
      cf_d      = sq_a_q;
      cs_d      = sq_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pfe_pkg::ST_IDLE;
      used_q     <= '0;
      fill_q     <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      fill_q     <= fill_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      idx_q      <= idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    b_placed_q <= b_placed_d;
    cf_q       <= cf_d;
    cs_q       <= cs_d;
  end

  // square and position tables, registered reads
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q]   <= place_l;
      pos_mem[place_l] <= fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_a_q <= pos_mem[a_q];
    pos_b_q <= pos_mem[b_q];
    sq_a_q  <= sq_mem[qa];
    sq_b_q  <= sq_mem[qb];
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.cipher_first  = cf_q;
  assign out_o.cipher_second = cs_q;

endmodule

// ===== tb/sv/playfair_digraph_encryptor_unit_test.sv =====
`timescale 1ns / 100ps

module playfair_digraph_encryptor_unit_test;
  import pfe_pkg::*;

  localparam int unsigned ItemTarget    = 1800;
  localparam int unsigned DrainCycles   = 80;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [OpW-1:0] OpTopUnused = '1;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
  } digraph_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfe_in_if  in_ch ();
  pfe_out_if out_ch ();
  pfe_cfg_if cfg_ch ();

  playfair_digraph_encryptor_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #2 clk_i = ~clk_i;

  // Square state as the block should hold it
  logic [LetterW-1:0] sq_tab [Cells];
  logic [CellW-1:0]   pos_tab [Letters];
  logic [Letters-1:0] placed;
  int unsigned        n_filled;
  logic [LetterW-1:0] open_letter;
  bit                 open_vld;
  logic [LetterW-1:0] omit_cfg;
  logic [LetterW-1:0] pad_cfg;

  digraph_t    digraph_q [$];
  int unsigned live_items;
  int unsigned fail_cnt;
  int unsigned burst_left;
  int unsigned hold_left;
  int unsigned idle_cycles;

  function automatic void queue_pair(digraph_t d);
    digraph_q.insert(digraph_q.size(), d);
  endfunction

  function automatic bit in_square(logic [LetterW-1:0] l);
    return (l < Letters) && placed[l];
  endfunction

  function automatic void add_letter(logic [LetterW-1:0] l);
    if (l >= Letters || n_filled >= Cells || placed[l] || l == omit_cfg) return;
    sq_tab[n_filled] = l;
    pos_tab[l] = CellW'(n_filled);
    placed[l] = 1'b1;
    n_filled++;
  endfunction

  function automatic int unsigned cell_index(logic [LetterW-1:0] l);
    return in_square(l) ? int'(pos_tab[l]) % Cells : 0;
  endfunction

  function automatic digraph_t encipher_pair(logic [LetterW-1:0] a, logic [LetterW-1:0] b);
    int unsigned pa, pb, ra, ca, rb, cb, qa, qb;
    digraph_t d;
    pa = cell_index(a);
    pb = cell_index(b);
    ra = pa / Side;
    ca = pa % Side;
    rb = pb / Side;
    cb = pb % Side;
    if (ra == rb) begin
      qa = ra * Side + (ca + 1) % Side;
      qb = rb * Side + (cb + 1) % Side;
    end else if (ca == cb) begin
      qa = ((ra + 1) % Side) * Side + ca;
      qb = ((rb + 1) % Side) * Side + cb;
    end else begin
      qa = ra * Side + cb;
      qb = rb * Side + ca;
    end
    d.first  = sq_tab[qa];
    d.second = sq_tab[qb];
    return d;
  endfunction

  function automatic void apply_item(logic [OpW-1:0] op, logic [LetterW-1:0] l);
    int unsigned k;
    bit full;
    full = (n_filled == Cells);
    case (op)
      OP_CLEAR: begin
        placed = '0;
        n_filled = 0;
        open_vld = 1'b0;
        open_letter = '0;
        live_items++;
      end
      OP_KEY: begin
        add_letter(l);
        live_items++;
      end
      OP_FINISH: begin
        for (k = 0; k < Letters; k++) add_letter(LetterW'(k));
        live_items++;
      end
      OP_MSG: begin
        if (full) begin
          live_items++;
          if (l < Letters && l != omit_cfg && in_square(l)) begin
            if (!open_vld) begin
              open_letter = l;
              open_vld = 1'b1;
            end else if (l == open_letter) begin
              queue_pair(encipher_pair(open_letter, pad_cfg));
            end else begin
              queue_pair(encipher_pair(open_letter, l));
              open_vld = 1'b0;
            end
          end
        end
      end
      OP_END: begin
        if (full) begin
          live_items++;
          if (open_vld) begin
            queue_pair(encipher_pair(open_letter, pad_cfg));
            open_vld = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [LetterW-1:0] ltr_of(byte c);
    return LetterW'(c - "a");
  endfunction

  function automatic logic [LetterW-1:0] any_letter();
    return LetterW'($urandom_range(0, (1 << LetterW) - 1));
  endfunction

  function automatic logic [LetterW-1:0] pick_key_letter();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return omit_cfg;
    if (r < 12) return LetterW'($urandom_range(Letters, (1 << LetterW) - 1));
    return LetterW'($urandom_range(0, Letters - 1));
  endfunction

  function automatic logic [LetterW-1:0] pick_msg_letter(logic [LetterW-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return prev;
    if (r < 17) return omit_cfg;
    if (r < 20) return LetterW'($urandom_range(Letters, (1 << LetterW) - 1));
    if (r < 26) return pad_cfg;
    return LetterW'($urandom_range(0, Letters - 1));
  endfunction

  task automatic push_item(input logic [OpW-1:0] op, input logic [LetterW-1:0] l);
    int unsigned gap, r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 3) gap = 0;
      else if (r < 8) gap = $urandom_range(1, 4);
      else gap = $urandom_range(5, 20);
      repeat (gap) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.letter <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    apply_item(op, l);
    burst_left--;
  endtask

  task automatic push_noise();
    push_item(OpW'($urandom_range(0, OpTopUnused)), any_letter());
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (digraph_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input pfe_cfg_e idx, input logic [LetterW-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == CFG_OMITTED) omit_cfg = val;
    else pad_cfg = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_keyed_message(input int unsigned key_len, input int unsigned msg_len,
                                    input bit do_finish);
    logic [LetterW-1:0] prev;
    int unsigned n;
    prev = LetterW'($urandom_range(0, Letters - 1));
    push_item(OP_CLEAR, any_letter());
    repeat (key_len) push_item(OP_KEY, pick_key_letter());
    if (do_finish) push_item(OP_FINISH, any_letter());
    for (n = 0; n < msg_len; n++) begin
      if ($urandom_range(0, 99) < 3) push_noise();
      if ($urandom_range(0, 99) < 5) push_item(OP_END, any_letter());
      prev = pick_msg_letter(prev);
      push_item(OP_MSG, prev);
    end
    push_item(OP_END, any_letter());
  endtask

  task automatic send_random_sequence();
    int unsigned key_len;
    key_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    send_keyed_message(key_len, $urandom_range(1, 40), $urandom_range(0, 9) != 0);
  endtask

  // Default q/x square keyed with "playz":
  //   p l a y z / b c d e f / g h i j k / m n o r s / t u v w x
  task automatic test_directed();
    push_item(OP_MSG, ltr_of("a"));
    push_item(OP_END, '0);
    push_item(OP_KEY, ltr_of("p"));
    push_item(OP_KEY, ltr_of("l"));
    push_item(OP_KEY, ltr_of("a"));
    push_item(OP_KEY, ltr_of("y"));
    push_item(OP_KEY, ltr_of("q"));
    push_item(OP_KEY, ltr_of("p"));
    push_item(OP_KEY, '1);
    push_item(OP_KEY, ltr_of("z"));
    push_item(OP_FINISH, '0);
    push_item(OP_MSG, ltr_of("q"));
    push_item(OP_MSG, '1);
    push_item(OP_MSG, ltr_of("p"));
    push_item(OP_MSG, ltr_of("z"));
    push_item(OP_MSG, ltr_of("a"));
    push_item(OP_MSG, ltr_of("v"));
    push_item(OP_MSG, ltr_of("b"));
    push_item(OP_MSG, ltr_of("b"));
    push_item(OP_MSG, ltr_of("k"));
    push_item(OP_MSG, ltr_of("x"));
    push_item(OP_END, '1);
    push_item(OP_END, '0);
    push_item(OpTopUnused, '1);
    push_item(OP_MSG, ltr_of("a"));
    push_item(OP_CLEAR, '1);
    push_item(OP_END, '0);
  endtask

  task automatic test_register_extremes();
    logic [LetterW-1:0] omit_set [4] = '{5'd0, 5'd25, 5'd7, ResetOmitted};
    logic [LetterW-1:0] pad_set [4]  = '{5'd25, 5'd0, 5'd7, ResetFiller};
    logic [LetterW-1:0] m;
    int unsigned k;
    for (k = 0; k < 4; k++) begin
      drain();
      write_reg(CFG_OMITTED, omit_set[k]);
      write_reg(CFG_FILLER, pad_set[k]);
      m = LetterW'((omit_set[k] + 1) % Letters);
      // doubled and trailing letters, filler possibly outside the square
      push_item(OP_CLEAR, '0);
      push_item(OP_FINISH, '1);
      push_item(OP_MSG, m);
      push_item(OP_MSG, m);
      push_item(OP_END, '0);
      send_random_sequence();
      send_random_sequence();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = LongHold;
    send_keyed_message(6, 40, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned seq_cnt;
    logic [LetterW-1:0] v;
    seq_cnt = 0;
    while (live_items < ItemTarget) begin
      if (seq_cnt % 8 == 7) begin
        drain();
        v = LetterW'($urandom_range(0, Letters - 1));
        write_reg(CFG_OMITTED, v);
        if ($urandom_range(0, 4) != 0) v = LetterW'($urandom_range(0, Letters - 1));
        write_reg(CFG_FILLER, v);
      end
      send_random_sequence();
      seq_cnt++;
    end
  endtask

  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 128) % 4)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 7) == 0);
          default: out_ch.ready <= ((cyc % 11) < 7);
        endcase
      end
      cyc++;
    end
  end

  always @(posedge clk_i) begin
    digraph_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (digraph_q.size() == 0) begin
        $error("unexpected digraph: %0d %0d", out_ch.cipher_first, out_ch.cipher_second);
        fail_cnt++;
      end else begin
        want = digraph_q.pop_front();
        if (out_ch.cipher_first !== want.first) begin
          $error("cipher_first: expected %0d, got %0d", want.first, out_ch.cipher_first);
          fail_cnt++;
        end
        if (out_ch.cipher_second !== want.second) begin
          $error("cipher_second: expected %0d, got %0d", want.second, out_ch.cipher_second);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.letter = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_OMITTED;
    cfg_ch.data  = '0;
    placed       = '0;
    n_filled     = 0;
    open_letter  = '0;
    open_vld     = 1'b0;
    omit_cfg     = ResetOmitted;
    pad_cfg      = ResetFiller;
    live_items   = 0;
    fail_cnt     = 0;
    burst_left   = 0;
    hold_left    = 0;
    idle_cycles  = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    drain();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
